@@ hdl/ddaf_pkg.sv @@
// Package for the dual-domain FIFO model: default sizes and the per-request result record.
// No dependencies; imported by the top level.
`timescale 1ns / 1ps
`default_nettype none

package ddaf_pkg;

    // Default sizes handed to the top-level parameters
    localparam int DEF_FIFO_DEPTH  = 8;
    localparam int DEF_SYNC_STAGES = 2;
    localparam int DEF_DATA_WIDTH  = 64;

    // Width of sequence counters and the reset epoch
    localparam int CNT_W = 32;

    // Control/status part of one result, carried through the pipeline
    typedef struct packed {
        logic             push_ready;
        logic             pop_valid;
        logic [CNT_W-1:0] epoch_seen;
        logic             link_active;
    } ddaf_result_t;

endpackage

`default_nettype wire

@@ hdl/ddaf_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module ddaf_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 8
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read, held while not enabled
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

@@ hdl/dual_domain_async_fifo.sv @@
// Top level of the dual-domain FIFO model: per-tick domain state, entry RAM and result pipeline.
// Depends on ddaf_pkg and ddaf_ram.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+------------------------------------------------
//  s_      | in        | s_valid / s_ready  | func, reset_n, push_valid, push_data, pop_ready
//  m_      | out       | m_valid / m_ready  | push_ready, pop_valid, pop_data, epoch_seen,
//          |           |                    | link_active
//
// One request is taken every cycle while s_ready is high; its result passes the entry RAM read
// register and then the output register. Domain state is updated in the cycle a request is
// taken, so the next request may follow at once; the RAM is read only on reader ticks.
// aresetn restores the post-reset state: entries are not cleared, as a reader
// can only reach entries written since the last clear.
// With the output stalled, one more request is taken into the RAM read stage; then s_ready
// drops until m_ready returns.
`timescale 1ns / 1ps
`default_nettype none

module dual_domain_async_fifo
    import ddaf_pkg::*;
#(
    parameter int FIFO_DEPTH  = DEF_FIFO_DEPTH,
    parameter int SYNC_STAGES = DEF_SYNC_STAGES,
    parameter int DATA_WIDTH  = DEF_DATA_WIDTH
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic        s_func,
    input  wire logic        s_reset_n,
    input  wire logic        s_push_valid,
    input  wire logic [63:0] s_push_data,
    input  wire logic        s_pop_ready,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic             m_push_ready,
    output logic             m_pop_valid,
    output logic [63:0]      m_pop_data,
    output logic [31:0]      m_epoch_seen,
    output logic             m_link_active
);

    localparam int               IDX_W    = $clog2(FIFO_DEPTH);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(FIFO_DEPTH - 1);
    localparam logic [CNT_W-1:0] DEPTH_C  = CNT_W'(FIFO_DEPTH);

    // domain state
    logic [CNT_W-1:0] wc_reg, wc_next, rc_reg, rc_next;
    logic [IDX_W-1:0] wr_idx_reg, wr_idx_next, rd_idx_reg, rd_idx_next;
    logic [CNT_W-1:0] wr_sync_reg [SYNC_STAGES];
    logic [CNT_W-1:0] wr_sync_next [SYNC_STAGES];
    logic [CNT_W-1:0] rd_sync_reg [SYNC_STAGES];
    logic [CNT_W-1:0] rd_sync_next [SYNC_STAGES];
    logic [CNT_W-1:0] epoch_reg, epoch_next;
    logic [CNT_W-1:0] wr_pipe0_reg, wr_pipe0_next, wr_pipe1_reg, wr_pipe1_next;
    logic [CNT_W-1:0] rd_pipe0_reg, rd_pipe0_next, rd_pipe1_reg, rd_pipe1_next;
    logic             wr_rel_reg, wr_rel_next, rd_rel_reg, rd_rel_next;
    logic             wr_seen_reg, wr_seen_next, rd_seen_reg, rd_seen_next;

    // pipeline
    logic             p1_valid_reg, p1_valid_next;
    ddaf_result_t     p1_res_reg;
    logic             m_valid_reg, m_valid_next;
    ddaf_result_t     m_res_reg;
    logic [63:0]      m_pop_data_reg;

    logic             s_accept, p1_move;
    ddaf_result_t     step_res;
    logic             ram_we, ram_re;
    logic [DATA_WIDTH-1:0] ram_rdata;

    logic [CNT_W-1:0] own_pipe0, own_pipe1, epoch_tmp, wr_vis, rd_vis;
    logic             own_rel, own_seen, other_rel, rel_tmp, room, avail;

    // handshake
    assign p1_move  = p1_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready  = !p1_valid_reg || !m_valid_reg || m_ready;
    assign s_accept = s_valid && s_ready;

    // visible counters and the room / fill tests
    assign rd_vis = rd_sync_reg[SYNC_STAGES-1];
    assign wr_vis = wr_sync_reg[SYNC_STAGES-1];
    assign room   = (wc_reg >= rd_vis) && ((wc_reg - rd_vis) < DEPTH_C);
    assign avail  = (wr_vis >= rc_reg) && ((wr_vis - rc_reg) <= DEPTH_C) && (wr_vis != rc_reg);

    // one tick of the selected domain
    always_comb begin
        wc_next       = wc_reg;
        rc_next       = rc_reg;
        wr_idx_next   = wr_idx_reg;
        rd_idx_next   = rd_idx_reg;
        wr_sync_next  = wr_sync_reg;
        rd_sync_next  = rd_sync_reg;
        epoch_next    = epoch_reg;
        wr_pipe0_next = wr_pipe0_reg;
        wr_pipe1_next = wr_pipe1_reg;
        rd_pipe0_next = rd_pipe0_reg;
        rd_pipe1_next = rd_pipe1_reg;
        wr_rel_next   = wr_rel_reg;
        rd_rel_next   = rd_rel_reg;
        wr_seen_next  = wr_seen_reg;
        rd_seen_next  = rd_seen_reg;
        ram_we        = 1'b0;
        ram_re        = 1'b0;
        step_res      = '0;
        epoch_tmp     = epoch_reg;
        rel_tmp       = 1'b0;

        own_pipe0 = s_func ? rd_pipe0_reg : wr_pipe0_reg;
        own_pipe1 = s_func ? rd_pipe1_reg : wr_pipe1_reg;
        own_rel   = s_func ? rd_rel_reg   : wr_rel_reg;
        own_seen  = s_func ? rd_seen_reg  : wr_seen_reg;
        other_rel = s_func ? wr_rel_reg   : rd_rel_reg;

        if (s_accept) begin
            if (!s_reset_n) begin
                // first reset tick clears the FIFO and opens a new epoch
                if (!own_seen) begin
                    wc_next     = '0;
                    rc_next     = '0;
                    wr_idx_next = '0;
                    rd_idx_next = '0;
                    for (int s = 0; s < SYNC_STAGES; s++) begin
                        wr_sync_next[s] = '0;
                        rd_sync_next[s] = '0;
                    end
                    wr_rel_next = 1'b0;
                    rd_rel_next = 1'b0;
                    epoch_tmp   = epoch_reg + 1'b1;
                end
                epoch_next = epoch_tmp;
                if (s_func) begin
                    rd_seen_next  = 1'b1;
                    rd_rel_next   = 1'b0;
                    rd_pipe0_next = epoch_tmp;
                    rd_pipe1_next = epoch_tmp;
                end else begin
                    wr_seen_next  = 1'b1;
                    wr_rel_next   = 1'b0;
                    wr_pipe0_next = epoch_tmp;
                    wr_pipe1_next = epoch_tmp;
                end
                step_res.epoch_seen  = epoch_tmp;
                step_res.link_active = 1'b0;
            end else begin
                step_res.epoch_seen  = own_pipe1;
                step_res.link_active = wr_rel_reg && rd_rel_reg;
                rel_tmp = own_rel;
                if (own_pipe1 != epoch_reg) begin
                    rel_tmp = 1'b0;
                end else if (!own_rel) begin
                    rel_tmp = 1'b1;
                end else if (other_rel) begin
                    if (!s_func) begin
                        // writer: push when there is room
                        step_res.push_ready = room;
                        if (room && s_push_valid) begin
                            ram_we  = 1'b1;
                            wc_next = wc_reg + 1'b1;
                            if (wc_reg == '1 || wr_idx_reg == IDX_LAST) begin
                                wr_idx_next = '0;
                            end else begin
                                wr_idx_next = wr_idx_reg + 1'b1;
                            end
                        end
                        rd_sync_next[0] = rc_reg;
                        for (int s = 1; s < SYNC_STAGES; s++) begin
                            rd_sync_next[s] = rd_sync_reg[s-1];
                        end
                    end else begin
                        // reader: head entry read from RAM, pop on pop_ready
                        step_res.pop_valid = avail;
                        ram_re = avail;
                        if (avail && s_pop_ready) begin
                            rc_next = rc_reg + 1'b1;
                            if (rc_reg == '1 || rd_idx_reg == IDX_LAST) begin
                                rd_idx_next = '0;
                            end else begin
                                rd_idx_next = rd_idx_reg + 1'b1;
                            end
                        end
                        wr_sync_next[0] = wc_reg;
                        for (int s = 1; s < SYNC_STAGES; s++) begin
                            wr_sync_next[s] = wr_sync_reg[s-1];
                        end
                    end
                end
                // epoch pipe shift
                if (s_func) begin
                    rd_seen_next  = 1'b0;
                    rd_rel_next   = rel_tmp;
                    rd_pipe1_next = own_pipe0;
                    rd_pipe0_next = epoch_reg;
                end else begin
                    wr_seen_next  = 1'b0;
                    wr_rel_next   = rel_tmp;
                    wr_pipe1_next = own_pipe0;
                    wr_pipe0_next = epoch_reg;
                end
            end
        end
    end

    // pipeline valid flags
    always_comb begin
        p1_valid_next = p1_valid_reg;
        if (s_accept) begin
            p1_valid_next = 1'b1;
        end else if (p1_move) begin
            p1_valid_next = 1'b0;
        end
        m_valid_next = m_valid_reg;
        if (p1_move) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wc_reg       <= '0;
            rc_reg       <= '0;
            wr_idx_reg   <= '0;
            rd_idx_reg   <= '0;
            for (int s = 0; s < SYNC_STAGES; s++) begin
                wr_sync_reg[s] <= '0;
                rd_sync_reg[s] <= '0;
            end
            epoch_reg    <= '0;
            wr_pipe0_reg <= '0;
            wr_pipe1_reg <= '0;
            rd_pipe0_reg <= '0;
            rd_pipe1_reg <= '0;
            wr_rel_reg   <= 1'b0;
            rd_rel_reg   <= 1'b0;
            wr_seen_reg  <= 1'b1;
            rd_seen_reg  <= 1'b1;
            p1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            wc_reg       <= wc_next;
            rc_reg       <= rc_next;
            wr_idx_reg   <= wr_idx_next;
            rd_idx_reg   <= rd_idx_next;
            wr_sync_reg  <= wr_sync_next;
            rd_sync_reg  <= rd_sync_next;
            epoch_reg    <= epoch_next;
            wr_pipe0_reg <= wr_pipe0_next;
            wr_pipe1_reg <= wr_pipe1_next;
            rd_pipe0_reg <= rd_pipe0_next;
            rd_pipe1_reg <= rd_pipe1_next;
            wr_rel_reg   <= wr_rel_next;
            rd_rel_reg   <= rd_rel_next;
            wr_seen_reg  <= wr_seen_next;
            rd_seen_reg  <= rd_seen_next;
            p1_valid_reg <= p1_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // result payload registers
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            p1_res_reg <= step_res;
        end
        if (p1_move) begin
            m_res_reg      <= p1_res_reg;
            m_pop_data_reg <= p1_res_reg.pop_valid ? 64'(ram_rdata) : 64'd0;
        end
    end

    // entry storage
    ddaf_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (FIFO_DEPTH)
    ) u_entries (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (wr_idx_reg),
        .wr_data (s_push_data[DATA_WIDTH-1:0]),
        .rd_en   (ram_re),
        .rd_addr (rd_idx_reg),
        .rd_data (ram_rdata)
    );

    // outputs
    assign m_valid       = m_valid_reg;
    assign m_push_ready  = m_res_reg.push_ready;
    assign m_pop_valid   = m_res_reg.pop_valid;
    assign m_pop_data    = m_pop_data_reg;
    assign m_epoch_seen  = m_res_reg.epoch_seen;
    assign m_link_active = m_res_reg.link_active;

`ifndef ASSERT_OFF
    // counters stay consistent: never more read than written, never over depth
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (rc_reg <= wc_reg) && ((wc_reg - rc_reg) <= DEPTH_C))
        else $error("outstanding entries out of range");

    // a result reports room or an entry, never both
    a_one_side: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_push_ready && m_pop_valid))
        else $error("push_ready and pop_valid together");

    // data is zero whenever no entry is shown
    a_data_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_pop_valid) |-> (m_pop_data == 64'd0))
        else $error("pop_data not zero without pop_valid");

    // link only reported active when both domains had released
    a_link: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && s_reset_n && !(wr_rel_reg && rd_rel_reg)) |=> !p1_res_reg.link_active)
        else $error("link_active without both domains released");
`endif

endmodule

`default_nettype wire

@@ dv/tb_dual_domain_async_fifo.sv @@
// Self-checking testbench for dual_domain_async_fifo: drives writer/reader tick requests,
// predicts each result with its own domain model and checks the result stream.
// Depends on ddaf_pkg and the dual_domain_async_fifo RTL.
`timescale 1ns / 1ps

module tb_dual_domain_async_fifo;
    import ddaf_pkg::*;

    localparam int RANDOM_REQUESTS = 1150;
    localparam int CYCLE_LIMIT     = 200000;
    localparam int DRAIN_TAIL      = 8;
    localparam int SHOW_LIMIT      = 10;

    // Which domain a request ticks
    typedef enum logic {
        DOM_WRITER = 1'b0,
        DOM_READER = 1'b1
    } domain_e;

    // Receiver behaviour on the result channel
    typedef enum logic [1:0] {
        RX_STEADY,
        RX_CHOPPY,
        RX_SLUGGISH
    } rx_mode_e;

    // One result as seen on the m_ ports
    typedef struct packed {
        logic        push_ready;
        logic        pop_valid;
        logic [63:0] pop_data;
        logic [31:0] epoch_seen;
        logic        link_active;
    } tick_result_t;

    // Domain-crossing FIFO predictor plus the queue of results still owed
    class fifo_link_scoreboard;
        bit [CNT_W-1:0] wr_cnt;
        bit [CNT_W-1:0] rd_cnt;
        bit [CNT_W-1:0] wr_cnt_sync [DEF_SYNC_STAGES];
        bit [CNT_W-1:0] rd_cnt_sync [DEF_SYNC_STAGES];
        bit [63:0]      slot [DEF_FIFO_DEPTH];
        bit [CNT_W-1:0] epoch;
        bit [CNT_W-1:0] epoch_pipe [2][2];
        bit             released [2];
        bit             reset_seen [2];
        tick_result_t   owed_q [$];
        int             mismatches;

        function new();
            clear_fifo();
            epoch = '0;
            foreach (epoch_pipe[d, s]) epoch_pipe[d][s] = '0;
            reset_seen[0] = 1'b1;
            reset_seen[1] = 1'b1;
            mismatches = 0;
        endfunction

        function void clear_fifo();
            wr_cnt = '0;
            rd_cnt = '0;
            foreach (wr_cnt_sync[s]) wr_cnt_sync[s] = '0;
            foreach (rd_cnt_sync[s]) rd_cnt_sync[s] = '0;
            foreach (slot[i]) slot[i] = '0;
            released[0] = 1'b0;
            released[1] = 1'b0;
        endfunction

        function int pending();
            return owed_q.size();
        endfunction

        // Advance the model by one accepted request and queue its result
        function void note_request(domain_e dom, bit rst_n, bit push_valid,
                                   bit [63:0] push_data, bit pop_ready);
            tick_result_t   r;
            int             d;
            bit             ok;
            bit [CNT_W-1:0] vis;
            r = '0;
            d = (dom == DOM_READER) ? 1 : 0;
            if (!rst_n) begin
                // first reset tick since running clears and bumps the epoch
                if (!reset_seen[d]) begin
                    clear_fifo();
                    epoch = epoch + 1;
                end
                reset_seen[d] = 1'b1;
                released[d]   = 1'b0;
                epoch_pipe[d][0] = epoch;
                epoch_pipe[d][1] = epoch;
                r.epoch_seen  = epoch_pipe[d][1];
                r.link_active = released[0] && released[1];
            end else begin
                r.epoch_seen  = epoch_pipe[d][1];
                r.link_active = released[0] && released[1];
                reset_seen[d] = 1'b0;
                if (epoch_pipe[d][1] != epoch) begin
                    released[d] = 1'b0;
                end else if (!released[d]) begin
                    released[d] = 1'b1;
                end else if (released[1-d]) begin
                    if (dom == DOM_WRITER) begin
                        vis = rd_cnt_sync[DEF_SYNC_STAGES-1];
                        ok  = (wr_cnt >= vis) && ((wr_cnt - vis) < DEF_FIFO_DEPTH);
                        r.push_ready = ok;
                        if (ok && push_valid) begin
                            slot[wr_cnt % DEF_FIFO_DEPTH] = push_data;
                            wr_cnt = wr_cnt + 1;
                        end
                        for (int s = DEF_SYNC_STAGES - 1; s > 0; s--)
                            rd_cnt_sync[s] = rd_cnt_sync[s-1];
                        rd_cnt_sync[0] = rd_cnt;
                    end else begin
                        vis = wr_cnt_sync[DEF_SYNC_STAGES-1];
                        ok  = (vis >= rd_cnt) && ((vis - rd_cnt) <= DEF_FIFO_DEPTH)
                              && (vis != rd_cnt);
                        if (ok) begin
                            r.pop_valid = 1'b1;
                            r.pop_data  = slot[rd_cnt % DEF_FIFO_DEPTH];
                            if (pop_ready) rd_cnt = rd_cnt + 1;
                        end
                        for (int s = DEF_SYNC_STAGES - 1; s > 0; s--)
                            wr_cnt_sync[s] = wr_cnt_sync[s-1];
                        wr_cnt_sync[0] = wr_cnt;
                    end
                end
                epoch_pipe[d][1] = epoch_pipe[d][0];
                epoch_pipe[d][0] = epoch;
            end
            owed_q.push_back(r);
        endfunction

        // Compare one delivered result with the oldest owed one
        function void check_result(tick_result_t got);
            tick_result_t want;
            if (owed_q.size() == 0) begin
                mismatches++;
                if (mismatches <= SHOW_LIMIT)
                    $display("[%0t] result with no request outstanding", $realtime);
                return;
            end
            want = owed_q.pop_front();
            if (got.push_ready !== want.push_ready || got.pop_valid !== want.pop_valid ||
                got.pop_data !== want.pop_data || got.epoch_seen !== want.epoch_seen ||
                got.link_active !== want.link_active) begin
                mismatches++;
                if (mismatches <= SHOW_LIMIT) begin
                    $display("[%0t] mismatch: push_ready %b/%b pop_valid %b/%b link %b/%b",
                             $realtime, want.push_ready, got.push_ready, want.pop_valid,
                             got.pop_valid, want.link_active, got.link_active);
                    $display("    pop_data %h/%h epoch_seen %h/%h (expected/actual)",
                             want.pop_data, got.pop_data, want.epoch_seen, got.epoch_seen);
                end
            end
        endfunction
    endclass

    logic        aclk          = 1'b0;
    logic        aresetn       = 1'b0;
    logic        s_valid       = 1'b0;
    logic        s_ready;
    logic        s_func        = 1'b0;
    logic        s_reset_n     = 1'b1;
    logic        s_push_valid  = 1'b0;
    logic [63:0] s_push_data   = '0;
    logic        s_pop_ready   = 1'b0;
    logic        m_valid;
    logic        m_ready       = 1'b0;
    logic        m_push_ready;
    logic        m_pop_valid;
    logic [63:0] m_pop_data;
    logic [31:0] m_epoch_seen;
    logic        m_link_active;

    fifo_link_scoreboard sb = new();
    int       burst_left = 0;
    int       cycle_count = 0;
    rx_mode_e rx_mode = RX_STEADY;
    int       rx_mode_left = 0;

    dual_domain_async_fifo DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_func        (s_func),
        .s_reset_n     (s_reset_n),
        .s_push_valid  (s_push_valid),
        .s_push_data   (s_push_data),
        .s_pop_ready   (s_pop_ready),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_push_ready  (m_push_ready),
        .m_pop_valid   (m_pop_valid),
        .m_pop_data    (m_pop_data),
        .m_epoch_seen  (m_epoch_seen),
        .m_link_active (m_link_active)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Run guard
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("** dual_domain_async_fifo: FAILED **");
            $finish;
        end
    end

    // Receiver: ready pattern switches between steady, choppy and sluggish stretches
    always @(posedge aclk) begin
        if (rx_mode_left == 0) begin
            rx_mode      <= rx_mode_e'($urandom_range(0, 2));
            rx_mode_left <= $urandom_range(40, 200);
        end else begin
            rx_mode_left <= rx_mode_left - 1;
        end
        case (rx_mode)
            RX_STEADY:   m_ready <= 1'b1;
            RX_CHOPPY:   m_ready <= 1'($urandom_range(0, 1));
            default:     m_ready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    // Monitor: results are checked before the request taken at the same edge is noted
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready)
                sb.check_result({m_push_ready, m_pop_valid, m_pop_data, m_epoch_seen,
                                 m_link_active});
            if (s_valid && s_ready)
                sb.note_request(domain_e'(s_func), s_reset_n, s_push_valid, s_push_data,
                                s_pop_ready);
        end
    end

    // Offer one request; bursts of random length separated by random gaps
    task automatic send_request(input domain_e dom, input logic rst_n, input logic push_valid,
                                input logic [63:0] push_data, input logic pop_ready);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 32);
        end
        s_valid      <= 1'b1;
        s_func       <= dom;
        s_reset_n    <= rst_n;
        s_push_valid <= push_valid;
        s_push_data  <= push_data;
        s_pop_ready  <= pop_ready;
        do @(posedge aclk); while (!s_ready);
        burst_left--;
    endtask

    // Payload word, with the extremes turning up now and then
    function automatic logic [63:0] pick_payload();
        case ($urandom_range(0, 15))
            0:       return '0;
            1:       return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // Random part: domain resets, then runs of running ticks with a varying mix
    task automatic run_random(input int target);
        int      sent;
        int      run_len;
        int      wr_pct;
        int      push_pct;
        int      pop_pct;
        bit      paused;
        domain_e dom;
        sent   = 0;
        paused = 1'b0;
        while (sent < target) begin
            if ($urandom_range(0, 9) == 0) begin
                dom = domain_e'($urandom_range(0, 1));
                repeat ($urandom_range(1, 3)) begin
                    send_request(dom, 1'b0, 1'($urandom_range(0, 1)), pick_payload(),
                                 1'($urandom_range(0, 1)));
                    sent++;
                end
                if ($urandom_range(0, 3) == 0) begin
                    send_request(domain_e'(~dom), 1'b0, 1'($urandom_range(0, 1)),
                                 pick_payload(), 1'($urandom_range(0, 1)));
                    sent++;
                end
            end
            case ($urandom_range(0, 2))
                0:       wr_pct = 25;
                1:       wr_pct = 50;
                default: wr_pct = 75;
            endcase
            push_pct = $urandom_range(30, 100);
            pop_pct  = $urandom_range(20, 100);
            run_len  = $urandom_range(10, 60);
            repeat (run_len) begin
                dom = ($urandom_range(0, 99) < wr_pct) ? DOM_WRITER : DOM_READER;
                // the odd stray reset tick as noise
                send_request(dom, ($urandom_range(0, 99) != 0),
                             ($urandom_range(0, 99) < push_pct), pick_payload(),
                             ($urandom_range(0, 99) < pop_pct));
                sent++;
            end
            // hold off once until the result channel has fully drained
            if (!paused && sent >= target / 2) begin
                s_valid <= 1'b0;
                do @(posedge aclk); while (sb.pending() != 0);
                burst_left = 0;
                paused     = 1'b1;
            end
        end
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // reset ticks straight after power-up: epoch must not advance
        send_request(DOM_WRITER, 1'b0, 1'b0, '0, 1'b0);
        send_request(DOM_READER, 1'b0, 1'b1, '1, 1'b1);
        // each domain releases itself
        send_request(DOM_WRITER, 1'b1, 1'b0, '0, 1'b0);
        send_request(DOM_READER, 1'b1, 1'b0, '0, 1'b0);
        // payload extremes
        send_request(DOM_WRITER, 1'b1, 1'b1, 64'h0, 1'b1);
        send_request(DOM_WRITER, 1'b1, 1'b1, '1, 1'b0);
        // reader: sync chain catches up, head held, then drained
        send_request(DOM_READER, 1'b1, 1'b1, '1, 1'b0);
        send_request(DOM_READER, 1'b1, 1'b0, '0, 1'b0);
        send_request(DOM_READER, 1'b1, 1'b0, '0, 1'b0);
        send_request(DOM_READER, 1'b1, 1'b0, '0, 1'b1);
        send_request(DOM_READER, 1'b1, 1'b0, '0, 1'b1);
        // writer fills the FIFO and runs into full
        repeat (9) send_request(DOM_WRITER, 1'b1, 1'b1, {$urandom, $urandom}, 1'b0);
        // reader reset while running: clear and epoch advance
        send_request(DOM_READER, 1'b0, 1'b0, '0, 1'b0);
        // writer held on stale epoch, releases, then waits for the reader
        repeat (4) send_request(DOM_WRITER, 1'b1, 1'b1, {$urandom, $urandom}, 1'b0);
        send_request(DOM_READER, 1'b1, 1'b0, '0, 1'b1);
        send_request(DOM_WRITER, 1'b1, 1'b1, '1, 1'b0);

        run_random(RANDOM_REQUESTS);

        // let the monitor note the last request before waiting for the drain
        s_valid <= 1'b0;
        do @(posedge aclk); while (sb.pending() != 0);
        repeat (DRAIN_TAIL) @(posedge aclk);
        if (sb.mismatches == 0) begin
            $display("** dual_domain_async_fifo: PASSED **");
        end else begin
            $display("** dual_domain_async_fifo: FAILED **");
        end
        $finish;
    end

endmodule
